/* hdl/ppid_pkg.sv */
// Package for the positional PID controller: state codes, register indexes,
// multiplier constants and the 24-bit saturation helper.
// No dependencies.
package ppid_pkg;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_ACC   = 6'b001000,
    ST_ADDI  = 6'b010000,
    ST_CLAMP = 6'b100000
  } state_t;

  localparam logic [2:0] CFG_KP   = 3'd0;
  localparam logic [2:0] CFG_KI   = 3'd1;
  localparam logic [2:0] CFG_KD   = 3'd2;
  localparam logic [2:0] CFG_ILIM = 3'd3;
  localparam logic [2:0] CFG_OLIM = 3'd4;

  localparam logic [14:0] ILIM_RST = 15'd7000;
  localparam logic [14:0] OLIM_RST = 15'd32767;

  localparam logic [1:0] MUL_KPD  = 2'd0;
  localparam logic [1:0] MUL_D    = 2'd1;
  localparam logic [1:0] MUL_P    = 2'd2;
  localparam logic [1:0] MUL_I    = 2'd3;

  localparam int MUL_STEPS = 18;

  localparam logic signed [15:0] DRIVE_NEG_FULL = 16'sh8000;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v > 25'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -25'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

/* hdl/positional_pid_controller.sv */
// Positional PID controller with integral anti-windup and output clamp.
// Uses ppid_pkg; one bit-serial shift-add multiplier is shared by all products.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_measured_value, in_target_value
//   out      output     out_valid/out_ready  out_drive, out_integral_clamped,
//                                            out_output_clamped
//   cfg      input      cfg_we               cfg_idx, cfg_data
//
// Each beat passes from acceptance to a loaded result through one prepare step,
// four shift-add products over an 18-bit multiplier operand, each followed by one
// accumulate step, then an integral add step and a clamp step.
// Reset is synchronous and active low; it restores gains, limits and the loop state.
// A new beat is taken once the previous one has reached the output register.
// A stalled result waits in the clamp cycle until the output register is free.
module positional_pid_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_measured_value,
  input  logic signed [15:0] in_target_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_drive,
  output logic               out_integral_clamped,
  output logic               out_output_clamped,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_data
);

  ppid_pkg::state_t state_r, state_nxt;

  logic signed [15:0] kp_r, ki_r, kd_r;
  logic [14:0]        ilim_r, olim_r;
  logic signed [23:0] sum_r;
  logic signed [16:0] prev_r;

  logic signed [16:0] err_r;
  logic signed [17:0] diff_r;
  logic signed [23:0] sum1_r;
  logic signed [23:0] a_r;
  logic signed [25:0] hi_r;
  logic [17:0]        lo_r;
  logic [4:0]         cnt_r;
  logic [1:0]         sel_r;
  logic signed [34:0] tot_r;
  logic signed [15:0] icl_r;
  logic               iflag_r;

  logic               out_valid_r;
  logic signed [15:0] drive_r;
  logic               iclamp_r, oclamp_r;

  logic               in_acc, out_free, last_step;
  logic signed [16:0] err_in;
  logic signed [17:0] diff_in;
  logic signed [25:0] a_ext, addend, psum;
  logic signed [43:0] prod;
  logic signed [35:0] prod_s;
  logic signed [31:0] i_val, lim_pos, lim_neg;
  logic               i_hi, i_lo;
  logic signed [34:0] olim_pos, olim_neg;
  logic               o_hi, o_lo;
  logic signed [15:0] drive_c;
  logic signed [23:0] sum1_in, sum_back;

  assign in_ready  = (state_r == ppid_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (cnt_r == 5'(ppid_pkg::MUL_STEPS - 1));

  assign err_in  = {in_target_value[15], in_target_value}
                 - {in_measured_value[15], in_measured_value};
  assign diff_in = {err_in[16], err_in} - {prev_r[16], prev_r};

  assign sum1_in  = ppid_pkg::sat24({sum_r[23], sum_r} + {{8{err_r[16]}}, err_r});
  assign sum_back = ppid_pkg::sat24({sum1_r[23], sum1_r} - {{8{err_r[16]}}, err_r});

  assign a_ext  = {{2{a_r[23]}}, a_r};
  assign addend = lo_r[0] ? (last_step ? -a_ext : a_ext) : 26'sd0;
  assign psum   = hi_r + addend;

  assign prod   = {hi_r, lo_r};
  assign prod_s = prod[43:8];

  assign i_val   = prod_s[31:0];
  assign lim_pos = {17'b0, ilim_r};
  assign lim_neg = -lim_pos;
  assign i_hi    = i_val > lim_pos;
  assign i_lo    = i_val < lim_neg;

  assign olim_pos = {20'b0, olim_r};
  assign olim_neg = -olim_pos;
  assign o_hi     = tot_r > olim_pos;
  assign o_lo     = tot_r < olim_neg;
  assign drive_c  = o_hi ? olim_pos[15:0] : (o_lo ? olim_neg[15:0] : tot_r[15:0]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppid_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = ppid_pkg::ST_PREP;
      end
      ppid_pkg::ST_PREP:  state_nxt = ppid_pkg::ST_MUL;
      ppid_pkg::ST_MUL: begin
        if (last_step) state_nxt = ppid_pkg::ST_ACC;
      end
      ppid_pkg::ST_ACC: begin
        state_nxt = (sel_r == ppid_pkg::MUL_I) ? ppid_pkg::ST_ADDI : ppid_pkg::ST_MUL;
      end
      ppid_pkg::ST_ADDI:  state_nxt = ppid_pkg::ST_CLAMP;
      ppid_pkg::ST_CLAMP: begin
        if (out_free) state_nxt = ppid_pkg::ST_IDLE;
      end
      default: state_nxt = ppid_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppid_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      prev_r      <= '0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      ilim_r      <= ppid_pkg::ILIM_RST;
      olim_r      <= ppid_pkg::OLIM_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ppid_pkg::ST_CLAMP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) prev_r <= err_in;
      if (state_r == ppid_pkg::ST_ADDI) sum_r <= iflag_r ? sum_back : sum1_r;
      if (cfg_we) begin
        unique case (cfg_idx)
          ppid_pkg::CFG_KP:   kp_r   <= cfg_data;
          ppid_pkg::CFG_KI:   ki_r   <= cfg_data;
          ppid_pkg::CFG_KD:   kd_r   <= cfg_data;
          ppid_pkg::CFG_ILIM: ilim_r <= cfg_data[14:0];
          ppid_pkg::CFG_OLIM: olim_r <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ppid_pkg::ST_IDLE: begin
        if (in_acc) begin
          err_r  <= err_in;
          diff_r <= diff_in;
        end
      end
      ppid_pkg::ST_PREP: begin
        sum1_r <= sum1_in;
        a_r    <= {{8{kd_r[15]}}, kd_r};
        lo_r   <= {{2{kp_r[15]}}, kp_r};
        hi_r   <= '0;
        cnt_r  <= '0;
        sel_r  <= ppid_pkg::MUL_KPD;
      end
      ppid_pkg::ST_MUL: begin
        hi_r  <= {psum[25], psum[25:1]};
        lo_r  <= {psum[0], lo_r[17:1]};
        cnt_r <= cnt_r + 5'd1;
      end
      ppid_pkg::ST_ACC: begin
        hi_r  <= '0;
        cnt_r <= '0;
        sel_r <= sel_r + 2'd1;
        case (sel_r)
          ppid_pkg::MUL_KPD: begin
            a_r  <= prod_s[23:0];
            lo_r <= diff_r;
          end
          ppid_pkg::MUL_D: begin
            tot_r <= prod_s[34:0];
            a_r   <= {{8{kp_r[15]}}, kp_r};
            lo_r  <= {err_r[16], err_r};
          end
          ppid_pkg::MUL_P: begin
            tot_r <= tot_r + {{10{prod_s[24]}}, prod_s[24:0]};
            a_r   <= sum1_r;
            lo_r  <= {{2{ki_r[15]}}, ki_r};
          end
          default: begin
            iflag_r <= i_hi || i_lo;
            icl_r   <= i_hi ? lim_pos[15:0] : (i_lo ? lim_neg[15:0] : i_val[15:0]);
          end
        endcase
      end
      ppid_pkg::ST_ADDI: begin
        tot_r <= tot_r + {{19{icl_r[15]}}, icl_r};
      end
      ppid_pkg::ST_CLAMP: begin
        if (out_free) begin
          drive_r  <= drive_c;
          iclamp_r <= iflag_r;
          oclamp_r <= o_hi || o_lo;
        end
      end
      default: ;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_drive            = drive_r;
  assign out_integral_clamped = iclamp_r;
  assign out_output_clamped   = oclamp_r;

endmodule

/* hdl/ppid_checker.sv */
// Port-level checker for the positional PID controller, bound to the top level.
// Uses ppid_pkg for the excluded drive code.
module ppid_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_drive,
  input logic               out_integral_clamped,
  input logic               out_output_clamped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive)
      && $stable(out_integral_clamped) && $stable(out_output_clamped))
    else $error("Result beat changed while stalled.");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive != ppid_pkg::DRIVE_NEG_FULL)
    else $error("Drive left the symmetric range.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken while a beat is in progress.");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("Result appeared the cycle after acceptance.");

endmodule

bind positional_pid_controller ppid_checker u_ppid_checker (.*);
